[rtl/rcf_pkg.sv]
// Shared types, constants and register codes for the RC channel filter block.
package rcf_pkg;

  localparam int PULSE_BITS_DEF = 12;
  localparam int NUM_CH         = 8;
  localparam int CH_W           = $clog2(NUM_CH);
  localparam int CFG_W          = 12;
  localparam int WIN_W          = 10;
  localparam int CNT_W          = 12;
  localparam int CFG_ADDR_W     = 3;

  localparam logic [CH_W-1:0]  THR_CH   = CH_W'(2);
  localparam logic [CH_W-1:0]  ROLL_CH  = CH_W'(3);
  localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(NUM_CH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THROTTLE_MIN = 3'd0,
    REG_ROLL_MIN     = 3'd1,
    REG_ROLL_MAX     = 3'd2,
    REG_STICK_WINDOW = 3'd3,
    REG_ARM_HOLD     = 3'd4,
    REG_DISARM_HOLD  = 3'd5
  } rcf_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] throttle_min;
    logic [CFG_W-1:0] roll_min;
    logic [CFG_W-1:0] roll_max;
    logic [WIN_W-1:0] stick_window;
    logic [CFG_W-1:0] arm_hold;
    logic [CFG_W-1:0] disarm_hold;
  } rcf_cfg_t;

  localparam rcf_cfg_t CFG_RESET = '{
    throttle_min: 12'd1000,
    roll_min:     12'd1000,
    roll_max:     12'd2000,
    stick_window: 10'd100,
    arm_hold:     12'd500,
    disarm_hold:  12'd100
  };

endpackage

[rtl/rcf_in_if.sv]
// Input channel: one frame of eight pulse captures plus the host-link flag.
interface rcf_in_if #(
  parameter int PW = rcf_pkg::PULSE_BITS_DEF
) ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] cap_ch0;
  logic [PW-1:0] cap_ch1;
  logic [PW-1:0] cap_ch2;
  logic [PW-1:0] cap_ch3;
  logic [PW-1:0] cap_ch4;
  logic [PW-1:0] cap_ch5;
  logic [PW-1:0] cap_ch6;
  logic [PW-1:0] cap_ch7;
  logic          host_linked;

  modport source (
    output valid, cap_ch0, cap_ch1, cap_ch2, cap_ch3,
           cap_ch4, cap_ch5, cap_ch6, cap_ch7, host_linked,
    input  ready
  );
  modport sink (
    input  valid, cap_ch0, cap_ch1, cap_ch2, cap_ch3,
           cap_ch4, cap_ch5, cap_ch6, cap_ch7, host_linked,
    output ready
  );
endinterface

[rtl/rcf_out_if.sv]
// Result channel: eight filtered pulse widths plus the armed flag.
interface rcf_out_if #(
  parameter int PW = rcf_pkg::PULSE_BITS_DEF
) ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] filt_ch0;
  logic [PW-1:0] filt_ch1;
  logic [PW-1:0] filt_ch2;
  logic [PW-1:0] filt_ch3;
  logic [PW-1:0] filt_ch4;
  logic [PW-1:0] filt_ch5;
  logic [PW-1:0] filt_ch6;
  logic [PW-1:0] filt_ch7;
  logic          armed;

  modport source (
    output valid, filt_ch0, filt_ch1, filt_ch2, filt_ch3,
           filt_ch4, filt_ch5, filt_ch6, filt_ch7, armed,
    input  ready
  );
  modport sink (
    input  valid, filt_ch0, filt_ch1, filt_ch2, filt_ch3,
           filt_ch4, filt_ch5, filt_ch6, filt_ch7, armed,
    output ready
  );
endinterface

[rtl/rcf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rcf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[rtl/rcf_gesture.sv]
// Stick-gesture hold counters and the armed flag.
module rcf_gesture #(
  parameter int PW = rcf_pkg::PULSE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [PW-1:0]     thr,
  input  logic [PW-1:0]     roll,
  input  rcf_pkg::rcf_cfg_t cfg,
  output logic              armed_nxt
);
  import rcf_pkg::*;

  localparam int GW = ((PW > CFG_W) ? PW : CFG_W) + 2;

  logic [CNT_W-1:0]    arm_cnt_r, arm_cnt_nxt;
  logic [CNT_W-1:0]    disarm_cnt_r, disarm_cnt_nxt;
  logic                armed_r;
  logic [CNT_W-1:0]    arm_bump, disarm_bump;
  logic signed [GW-1:0] thr_s, roll_s, w_s, tmin_s, rmin_s, rmax_s;
  logic                thr_low, roll_high, roll_low, arm_hit, disarm_hit;
  logic                arm_fire, disarm_fire;

  always_comb begin
    thr_s  = $signed(GW'(thr));
    roll_s = $signed(GW'(roll));
    w_s    = $signed(GW'(cfg.stick_window));
    tmin_s = $signed(GW'(cfg.throttle_min));
    rmin_s = $signed(GW'(cfg.roll_min));
    rmax_s = $signed(GW'(cfg.roll_max));

    thr_low   = (tmin_s - w_s < thr_s) && (thr_s < tmin_s + w_s);
    roll_high = (rmax_s - w_s < roll_s);
    roll_low  = (rmin_s - w_s < roll_s) && (roll_s < rmin_s + w_s);
    arm_hit    = thr_low && roll_high;
    disarm_hit = thr_low && roll_low;

    arm_bump    = (arm_cnt_r == CNT_MAX) ? CNT_MAX : arm_cnt_r + 1'b1;
    disarm_bump = (disarm_cnt_r == CNT_MAX) ? CNT_MAX : disarm_cnt_r + 1'b1;
    arm_fire    = arm_hit && (arm_bump > cfg.arm_hold);
    disarm_fire = disarm_hit && (disarm_bump > cfg.disarm_hold);

    arm_cnt_nxt    = arm_cnt_r;
    disarm_cnt_nxt = disarm_cnt_r;
    armed_nxt      = armed_r;
    if (en) begin
      arm_cnt_nxt    = (arm_hit && !arm_fire) ? arm_bump : '0;
      disarm_cnt_nxt = (disarm_hit && !disarm_fire) ? disarm_bump : '0;
      // disarm is checked first and wins
      if (disarm_fire) begin
        armed_nxt = 1'b0;
      end else if (arm_fire) begin
        armed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_cnt_r    <= '0;
      disarm_cnt_r <= '0;
      armed_r      <= 1'b0;
    end else begin
      arm_cnt_r    <= arm_cnt_nxt;
      disarm_cnt_r <= disarm_cnt_nxt;
      armed_r      <= armed_nxt;
    end
  end
endmodule

[rtl/rc_channel_filter_arm_detect.sv]
// Top level: eight-channel RC pulse filter with stick-gesture arming.
//
// in_if takes one word per frame: eight pulse captures and host_linked.
// out_if gives one word per frame: the eight filtered channels and armed.
// The configuration port writes a calibration register when cfg_we is high
// (index on cfg_addr); unknown indexes are ignored. Write it only while idle.
//
// Filter state lives in an 8-entry RAM. Each channel is read, blended as
// floor((9*old + new) / 10) and written back, one channel per cycle unless
// the output stalls; a new frame may enter the input slot as the last channel
// of the current one is read. The first frame after reset seeds the filter
// with its own captures. The gesture counters update once per frame on the
// last channel, unless host_linked is set.
//
// Reset clears the pipeline, the counters and armed, and restores default
// calibration; no RAM clearing pass is needed. A stalled output word holds
// in its register; the pipeline stops only when a finished frame meets a
// full output register; an empty input slot still takes a new frame.
module rc_channel_filter_arm_detect #(
  parameter int PULSE_BITS = rcf_pkg::PULSE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rcf_in_if.sink                           in_if,
  rcf_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [rcf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rcf_pkg::CFG_W-1:0]        cfg_wdata
);
  import rcf_pkg::*;

  localparam int PW    = PULSE_BITS;
  localparam int SUM_W = PW + 4;
  localparam int SH    = SUM_W + 4;
  localparam int MW    = SUM_W + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'd9) / 64'd10;
  localparam logic [MW-1:0]   RECIP   = MW'(RECIP_L);

  rcf_cfg_t cfg_r;

  logic [PW-1:0]   in_cap [NUM_CH];
  logic            in_accept;
  logic            frame_full_r;
  logic [CH_W-1:0] rd_idx_r;
  logic            first_r;
  logic [PW-1:0]   frame_cap_r [NUM_CH];
  logic            frame_link_r, frame_first_r;
  logic            issue, last_issue, stall;

  logic            s1_valid_r, s1_first_r, s1_link_r;
  logic [CH_W-1:0] s1_idx_r;
  logic [PW-1:0]   s1_cap_r;
  logic [PW-1:0]   ram_rdata, s1_old;
  logic [SUM_W-1:0] s1_sum;

  logic             s2_valid_r, s2_link_r, s2_last;
  logic [CH_W-1:0]  s2_idx_r;
  logic [SUM_W-1:0] s2_sum_r;
  logic [SUM_W+MW-1:0] s2_prod;
  logic [PW-1:0]    s2_q;

  logic [PW-1:0] res_r [NUM_CH];
  logic [PW-1:0] thr_r, roll_r;
  logic          gest_en, armed_nxt;
  logic          out_load, out_valid_r, out_armed_r;
  logic [PW-1:0] out_filt_r [NUM_CH];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (rcf_reg_e'(cfg_addr))
        REG_THROTTLE_MIN: cfg_r.throttle_min <= cfg_wdata;
        REG_ROLL_MIN:     cfg_r.roll_min     <= cfg_wdata;
        REG_ROLL_MAX:     cfg_r.roll_max     <= cfg_wdata;
        REG_STICK_WINDOW: cfg_r.stick_window <= cfg_wdata[WIN_W-1:0];
        REG_ARM_HOLD:     cfg_r.arm_hold     <= cfg_wdata;
        REG_DISARM_HOLD:  cfg_r.disarm_hold  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input slot and read sequencer
  assign in_cap[0] = in_if.cap_ch0;
  assign in_cap[1] = in_if.cap_ch1;
  assign in_cap[2] = in_if.cap_ch2;
  assign in_cap[3] = in_if.cap_ch3;
  assign in_cap[4] = in_if.cap_ch4;
  assign in_cap[5] = in_if.cap_ch5;
  assign in_cap[6] = in_if.cap_ch6;
  assign in_cap[7] = in_if.cap_ch7;

  assign s2_last     = s2_valid_r && (s2_idx_r == LAST_CH);
  assign stall       = s2_last && out_valid_r && !out_if.ready;
  assign issue       = frame_full_r && !stall;
  assign last_issue  = issue && (rd_idx_r == LAST_CH);
  assign in_if.ready = !frame_full_r || last_issue;
  assign in_accept   = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_full_r <= 1'b0;
      rd_idx_r     <= '0;
      first_r      <= 1'b1;
    end else begin
      if (in_accept) begin
        frame_full_r <= 1'b1;
        first_r      <= 1'b0;
      end else if (last_issue) begin
        frame_full_r <= 1'b0;
      end
      if (issue) begin
        rd_idx_r <= (rd_idx_r == LAST_CH) ? '0 : rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_cap_r   <= in_cap;
      frame_link_r  <= in_if.host_linked;
      frame_first_r <= first_r;
    end
  end

  rcf_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_CH)
  ) u_filt_ram (
    .clk   (clk),
    .we    (s2_valid_r && !stall),
    .waddr (s2_idx_r),
    .wdata (s2_q),
    .re    (issue),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // stage 1: blend sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!stall) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_cap_r   <= frame_cap_r[rd_idx_r];
      s1_idx_r   <= rd_idx_r;
      s1_first_r <= frame_first_r;
      s1_link_r  <= frame_link_r;
    end
  end

  assign s1_old = s1_first_r ? s1_cap_r : ram_rdata;
  assign s1_sum = SUM_W'({s1_old, 3'b000}) + SUM_W'(s1_old) + SUM_W'(s1_cap_r);

  // stage 2: divide by ten via reciprocal, write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!stall) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_sum_r  <= s1_sum;
      s2_idx_r  <= s1_idx_r;
      s2_link_r <= s1_link_r;
    end
  end

  assign s2_prod = (SUM_W+MW)'(s2_sum_r) * (SUM_W+MW)'(RECIP);
  assign s2_q    = s2_prod[SH +: PW];

  always_ff @(posedge clk) begin
    if (s2_valid_r && !stall) begin
      res_r[s2_idx_r] <= s2_q;
      if (s2_idx_r == THR_CH) begin
        thr_r <= s2_q;
      end
      if (s2_idx_r == ROLL_CH) begin
        roll_r <= s2_q;
      end
    end
  end

  assign out_load = s2_last && !stall;
  assign gest_en  = out_load && !s2_link_r;

  rcf_gesture #(
    .PW (PW)
  ) u_gesture (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (gest_en),
    .thr       (thr_r),
    .roll      (roll_r),
    .cfg       (cfg_r),
    .armed_nxt (armed_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        out_filt_r[i] <= (CH_W'(i) == LAST_CH) ? s2_q : res_r[i];
      end
      out_armed_r <= armed_nxt;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.filt_ch0 = out_filt_r[0];
  assign out_if.filt_ch1 = out_filt_r[1];
  assign out_if.filt_ch2 = out_filt_r[2];
  assign out_if.filt_ch3 = out_filt_r[3];
  assign out_if.filt_ch4 = out_filt_r[4];
  assign out_if.filt_ch5 = out_filt_r[5];
  assign out_if.filt_ch6 = out_filt_r[6];
  assign out_if.filt_ch7 = out_filt_r[7];
  assign out_if.armed    = out_armed_r;
endmodule

[rtl/rcf_checker.sv]
// Port-level checks for the RC channel filter, bound to the top level.
module rcf_checker #(
  parameter int PW = rcf_pkg::PULSE_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_armed,
  input logic [PW-1:0] out_filt_ch2
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_armed) && $stable(out_filt_ch2))
    else $error("output word changed while stalled");

  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input slot took a second word before draining");

  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && in_ready)
    else $error("block not idle after reset");
endmodule

bind rc_channel_filter_arm_detect rcf_checker #(
  .PW (PULSE_BITS)
) u_rcf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_armed    (out_if.armed),
  .out_filt_ch2 (out_if.filt_ch2)
);
